// File: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define MRR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define MRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/mrr_pkg.sv
package mrr_pkg;

  // datapath width of candidate, seed and all residues
  localparam int MR_W  = 32;
  // counter width for bit positions 0 .. MR_W-1
  localparam int MR_CW = $clog2(MR_W);
  localparam logic [MR_CW-1:0] CNT_LAST = MR_CW'(MR_W - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_SPLIT,
    S_REDUCE,
    S_EXP_INIT,
    S_EXP_SQ,
    S_EXP_ML,
    S_EXP_NX,
    S_MUL,
    S_CHECK,
    S_LOOP,
    S_LTEST,
    S_OUT
  } state_t;

  // where a modular product returns to
  typedef enum logic [1:0] {
    RET_SQ,
    RET_ML,
    RET_LP
  } ret_t;

endpackage

// File: src/miller_rabin_round_top.sv
// One Miller-Rabin witness round per request.
// Input channel: in_valid / in_stall carry in_candidate and in_witness_seed; a request
// is taken when in_valid is high and in_stall is low. Only one request is worked on at
// a time, so in_stall is high from the cycle after acceptance until the result has been
// written into the output register.
// Output channel: out_valid / out_stall carry out_probably_prime and
// out_decided_directly. The output register holds a result while out_stall is high, and
// the next request is accepted meanwhile; its result waits until the register frees.
// Schedule: candidates below four or even go from classification straight to the output
// register. Odd candidates of five and up run a bit-serial schedule: factors of two are
// stripped from n-1, the seed is reduced bit by bit by restoring reduction, then the
// 32 exponent bits are worked through by square-and-multiply, each modular product built
// from one doubling and one conditional add per multiplier bit, and up to s-1 further
// squarings follow. A single shared modular multiplier serves every squaring and product.
// Reset (rst_n low, synchronous) returns the controller to idle and empties the output
// register; no other state needs clearing.
module miller_rabin_round_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_candidate,
  input  logic [31:0] in_witness_seed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_probably_prime,
  output logic        out_decided_directly
);
  import mrr_pkg::*;

`include "assert_macros.svh"

  state_t             state_r, state_nxt;
  ret_t               ret_r, ret_nxt;
  logic [MR_W-1:0]    n_r, n_nxt;
  logic [MR_W-1:0]    nm1_r, nm1_nxt;
  logic [MR_W-1:0]    seed_r, seed_nxt;
  logic [MR_W-1:0]    m_r, m_nxt;
  logic [MR_W-1:0]    rem_r, rem_nxt;
  logic [MR_W-1:0]    d_r, d_nxt;
  logic [MR_W-1:0]    a_r, a_nxt;
  logic [MR_W-1:0]    x_r, x_nxt;
  logic [MR_W-1:0]    mul_a_r, mul_a_nxt;
  logic [MR_W-1:0]    mul_b_r, mul_b_nxt;
  logic [MR_W-1:0]    acc_r, acc_nxt;
  logic [MR_CW-1:0]   s_r, s_nxt;
  logic [MR_CW-1:0]   i_r, i_nxt;
  logic [MR_CW-1:0]   cnt_r, cnt_nxt;
  logic [MR_CW-1:0]   mcnt_r, mcnt_nxt;
  logic               mph_r, mph_nxt;
  logic               pass_r, pass_nxt;
  logic               direct_r, direct_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_prime_r, out_prime_nxt;
  logic               out_direct_r, out_direct_nxt;

  logic [MR_W:0]      red_t;
  logic               red_ge;
  logic [MR_W-1:0]    red_res;
  logic [MR_W:0]      dbl_t;
  logic [MR_W-1:0]    dbl_res;
  logic [MR_W:0]      sum_t;
  logic [MR_W-1:0]    sum_res;
  logic [MR_W-1:0]    mul_res;
  logic               mul_done;
  logic               is_direct;
  logic               out_load;

  // restoring reduction step: shift in one seed bit, subtract modulus if it fits
  always_comb begin
    red_t   = {rem_r, seed_r[MR_W-1]};
    red_ge  = (red_t >= {1'b0, m_r});
    red_res = red_ge ? MR_W'(red_t - {1'b0, m_r}) : red_t[MR_W-1:0];
  end

  // modular product step: doubling in phase 0, conditional add in phase 1
  always_comb begin
    dbl_t    = {acc_r, 1'b0};
    dbl_res  = (dbl_t >= {1'b0, n_r}) ? MR_W'(dbl_t - {1'b0, n_r}) : dbl_t[MR_W-1:0];
    sum_t    = {1'b0, acc_r} + {1'b0, mul_a_r};
    sum_res  = (sum_t >= {1'b0, n_r}) ? MR_W'(sum_t - {1'b0, n_r}) : sum_t[MR_W-1:0];
    mul_res  = mul_b_r[MR_W-1] ? sum_res : acc_r;
    mul_done = mph_r && (mcnt_r == CNT_LAST);
  end

  // small and even candidates need no witness
  assign is_direct = (n_r < MR_W'(4)) || !n_r[0];
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_CLASS;
      S_CLASS:    state_nxt = is_direct ? S_OUT : S_SPLIT;
      S_SPLIT:    if (d_r[0]) state_nxt = S_REDUCE;
      S_REDUCE:   if (cnt_r == CNT_LAST) state_nxt = S_EXP_INIT;
      S_EXP_INIT: state_nxt = S_EXP_SQ;
      S_EXP_SQ:   state_nxt = S_MUL;
      S_MUL: begin
        if (mul_done) begin
          unique case (ret_r)
            RET_SQ:  state_nxt = S_EXP_ML;
            RET_ML:  state_nxt = S_EXP_NX;
            RET_LP:  state_nxt = S_LTEST;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_EXP_ML:   state_nxt = d_r[MR_W-1] ? S_MUL : S_EXP_NX;
      S_EXP_NX:   state_nxt = (cnt_r == CNT_LAST) ? S_CHECK : S_EXP_SQ;
      S_CHECK:    state_nxt = ((x_r == MR_W'(1)) || (x_r == nm1_r)) ? S_OUT : S_LOOP;
      S_LOOP:     state_nxt = (i_r >= s_r) ? S_OUT : S_MUL;
      S_LTEST:    state_nxt = (x_r == nm1_r) ? S_OUT : S_LOOP;
      S_OUT:      if (out_load) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath registers
  always_comb begin
    n_nxt      = n_r;
    nm1_nxt    = nm1_r;
    seed_nxt   = seed_r;
    m_nxt      = m_r;
    rem_nxt    = rem_r;
    d_nxt      = d_r;
    a_nxt      = a_r;
    x_nxt      = x_r;
    mul_a_nxt  = mul_a_r;
    mul_b_nxt  = mul_b_r;
    acc_nxt    = acc_r;
    s_nxt      = s_r;
    i_nxt      = i_r;
    cnt_nxt    = cnt_r;
    mcnt_nxt   = mcnt_r;
    mph_nxt    = mph_r;
    ret_nxt    = ret_r;
    pass_nxt   = pass_r;
    direct_nxt = direct_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt    = in_candidate[MR_W-1:0];
          seed_nxt = in_witness_seed[MR_W-1:0];
        end
      end
      S_CLASS: begin
        direct_nxt = is_direct;
        pass_nxt   = (n_r == MR_W'(2)) || (n_r == MR_W'(3));
        nm1_nxt    = n_r - MR_W'(1);
        d_nxt      = n_r - MR_W'(1);
        m_nxt      = n_r - MR_W'(4);
        s_nxt      = '0;
        rem_nxt    = '0;
        cnt_nxt    = '0;
      end
      S_SPLIT: begin
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          s_nxt = s_r + MR_CW'(1);
        end
      end
      S_REDUCE: begin
        rem_nxt  = red_res;
        seed_nxt = seed_r << 1;
        cnt_nxt  = cnt_r + MR_CW'(1);
      end
      S_EXP_INIT: begin
        a_nxt   = rem_r + MR_W'(2);
        x_nxt   = MR_W'(1);
        cnt_nxt = '0;
      end
      S_EXP_SQ: begin
        mul_a_nxt = x_r;
        mul_b_nxt = x_r;
        acc_nxt   = '0;
        mcnt_nxt  = '0;
        mph_nxt   = 1'b0;
        ret_nxt   = RET_SQ;
      end
      S_MUL: begin
        if (!mph_r) begin
          acc_nxt = dbl_res;
          mph_nxt = 1'b1;
        end else begin
          acc_nxt   = mul_res;
          mul_b_nxt = mul_b_r << 1;
          mcnt_nxt  = mcnt_r + MR_CW'(1);
          mph_nxt   = 1'b0;
          if (mul_done) x_nxt = mul_res;
        end
      end
      S_EXP_ML: begin
        if (d_r[MR_W-1]) begin
          mul_a_nxt = a_r;
          mul_b_nxt = x_r;
          acc_nxt   = '0;
          mcnt_nxt  = '0;
          mph_nxt   = 1'b0;
          ret_nxt   = RET_ML;
        end
      end
      S_EXP_NX: begin
        d_nxt   = d_r << 1;
        cnt_nxt = cnt_r + MR_CW'(1);
      end
      S_CHECK: begin
        pass_nxt = (x_r == MR_W'(1)) || (x_r == nm1_r);
        i_nxt    = MR_CW'(1);
      end
      S_LOOP: begin
        if (i_r >= s_r) begin
          pass_nxt = 1'b0;
        end else begin
          mul_a_nxt = x_r;
          mul_b_nxt = x_r;
          acc_nxt   = '0;
          mcnt_nxt  = '0;
          mph_nxt   = 1'b0;
          ret_nxt   = RET_LP;
        end
      end
      S_LTEST: begin
        pass_nxt = (x_r == nm1_r);
        i_nxt    = i_r + MR_CW'(1);
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_prime_nxt  = out_prime_r;
    out_direct_nxt = out_direct_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_prime_nxt  = pass_r;
      out_direct_nxt = direct_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // port outputs
  always_comb begin
    in_stall             = (state_r != S_IDLE);
    out_valid            = out_valid_r;
    out_probably_prime   = out_prime_r;
    out_decided_directly = out_direct_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r          <= n_nxt;
    nm1_r        <= nm1_nxt;
    seed_r       <= seed_nxt;
    m_r          <= m_nxt;
    rem_r        <= rem_nxt;
    d_r          <= d_nxt;
    a_r          <= a_nxt;
    x_r          <= x_nxt;
    mul_a_r      <= mul_a_nxt;
    mul_b_r      <= mul_b_nxt;
    acc_r        <= acc_nxt;
    s_r          <= s_nxt;
    i_r          <= i_nxt;
    cnt_r        <= cnt_nxt;
    mcnt_r       <= mcnt_nxt;
    mph_r        <= mph_nxt;
    ret_r        <= ret_nxt;
    pass_r       <= pass_nxt;
    direct_r     <= direct_nxt;
    out_prime_r  <= out_prime_nxt;
    out_direct_r <= out_direct_nxt;
  end

  // an accepted request always leaves idle
  `MRR_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_r == S_CLASS)
  // the product accumulator stays a residue of the candidate
  `MRR_ASSERT_SAME(a_acc_residue, state_r == S_MUL, acc_r < n_r)
  // the seed remainder stays below its modulus
  `MRR_ASSERT_SAME(a_rem_bound, state_r == S_REDUCE, rem_r < m_r)
  // a held result is not overwritten
  `MRR_ASSERT_NEXT(a_out_hold, out_valid && out_stall && state_r != S_OUT,
                   out_valid && $stable(out_probably_prime))

endmodule
